/* design/sipsm_pkg.sv */
// Shared types, pattern text and match functions for the SIP signature matcher.
// No dependencies; used by the request interface, the cell and the top level.
package sipsm_pkg;

   localparam int BYTE_W     = 8;
   localparam int NUM_KEYS   = 15;
   localparam int KEY_UPDATE = 13;
   localparam int NUM_TRIE   = 89;
   localparam int NUM_SCAN   = 7;

   localparam logic [BYTE_W-1:0] PAT_DIGIT = "#";
   localparam logic [BYTE_W-1:0] PAT_ALT   = "%";
   localparam logic [BYTE_W-1:0] CHR_NUL   = 8'h00;

   localparam int KEY_LEN [NUM_KEYS] = '{3, 3, 6, 4, 6, 7, 6, 7, 5, 7, 5, 8, 9, 6, 7};

   localparam logic [BYTE_W*NUM_TRIE-1:0] TRIE_TEXT =
      {"ACKBYECANCELINFOINVITEMESSAGENOTIFYOPTIONSPRACKPUBLISH",
       "REFERREGISTERSUBSCRIBEUPDATESIP/#.#"};
   localparam logic [BYTE_W*NUM_SCAN-1:0] SCAN_TEXT = "SIP/#.%";

   typedef struct packed {
      logic step;
      logic clear;
   } cell_ctrl_type;

   function automatic logic char_fits(input logic [BYTE_W-1:0] pat,
                                      input logic [BYTE_W-1:0] c);
      logic fits;
      if (pat == PAT_DIGIT) begin
         fits = (c >= "0") && (c <= "9");
      end else if (pat == PAT_ALT) begin
         fits = (c == "0") || (c == ".") || (c == "9");
      end else begin
         fits = (c == pat);
      end
      return fits;
   endfunction

   function automatic int key_base(input int k);
      int b;
      b = 0;
      for (int j = 0; j < NUM_KEYS; j++) begin
         if (j < k) begin
            b = b + KEY_LEN[j];
         end
      end
      return b;
   endfunction

   function automatic logic key_start(input int i);
      logic hit;
      hit = 1'b0;
      for (int j = 0; j < NUM_KEYS; j++) begin
         if (key_base(j) == i) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   function automatic logic [NUM_TRIE-1:0] key_end_mask();
      logic [NUM_TRIE-1:0] mask;
      mask = '0;
      for (int j = 0; j < NUM_KEYS; j++) begin
         if (j != KEY_UPDATE) begin
            mask[key_base(j) + KEY_LEN[j] - 1] = 1'b1;
         end
      end
      return mask;
   endfunction

   function automatic logic [BYTE_W-1:0] trie_char(input int i);
      return TRIE_TEXT[BYTE_W*(NUM_TRIE-1-i) +: BYTE_W];
   endfunction

   function automatic logic [BYTE_W-1:0] scan_char(input int i);
      return SCAN_TEXT[BYTE_W*(NUM_SCAN-1-i) +: BYTE_W];
   endfunction

   localparam int UPD_END = key_base(KEY_UPDATE) + KEY_LEN[KEY_UPDATE] - 1;
   localparam logic [NUM_TRIE-1:0] KEY_END_MASK = key_end_mask();

endpackage

/* design/sipsm_req_if.sv */
// Request channel: one payload word per handshake.
// Depends on sipsm_pkg for the byte width.
interface sipsm_req_if;
   logic                          valid;
   logic                          ready;
   logic [sipsm_pkg::BYTE_W-1:0]  payload_byte;
   logic                          last_byte;

   modport source (output valid, output payload_byte, output last_byte, input ready);
   modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

/* design/sipsm_rsp_if.sv */
// Response channel: one match flag word per payload.
// No dependencies.
interface sipsm_rsp_if;
   logic valid;
   logic ready;
   logic is_sip;

   modport source (output valid, output is_sip, input ready);
   modport sink   (input valid, input is_sip, output ready);
endinterface

/* design/sipsm_cell.sv */
// One pattern cell: holds the matched-so-far bit of one pattern position.
// Depends on sipsm_pkg for the control struct and the character test.
module sipsm_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  sipsm_pkg::cell_ctrl_type      ctrl,
   input  logic                          feed,
   input  logic [sipsm_pkg::BYTE_W-1:0]  pat_char,
   input  logic [sipsm_pkg::BYTE_W-1:0]  data_byte,
   output logic                          active_out,
   output logic                          fit_out
);

   logic active_ff;
   logic active_in;

   assign fit_out    = feed & sipsm_pkg::char_fits(pat_char, data_byte);
   assign active_in  = ctrl.step ? fit_out : active_ff;
   assign active_out = active_ff;

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

endmodule

/* design/sip_signature_matcher.sv */
// SIP signature matcher: a row of keyword cells and a row of scan cells after UPDATE.
// Response: the match flag is registered in the cycle after the last word is accepted.
// Throughput: one payload word per cycle unless an untaken response stalls the input.
// Reset: synchronous; sets start, clears every cell, other flags and rsp valid; not is_sip.
// Depends on sipsm_pkg, sipsm_req_if, sipsm_rsp_if and sipsm_cell.
module sip_signature_matcher (
   input  logic          clock,
   input  logic          reset,
   sipsm_req_if.sink     req_chan,
   sipsm_rsp_if.source   rsp_chan
);

   localparam int NT = sipsm_pkg::NUM_TRIE;
   localparam int NS = sipsm_pkg::NUM_SCAN;

   logic                          accept;
   logic [sipsm_pkg::BYTE_W-1:0]  data_byte;
   logic                          zero_byte;
   logic                          live_byte;
   logic                          trie_step;
   logic                          scan_step;
   logic                          clear;
   logic                          key_done;
   logic                          upd_done;
   logic                          scan_done;
   logic                          match_now;

   logic start_ff,   start_in;
   logic ended_ff,   ended_in;
   logic match_ff,   match_in;
   logic scan_on_ff, scan_on_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic is_sip_ff,    is_sip_in;

   logic [NT-1:0] trie_act;
   logic [NT-1:0] trie_fit;
   logic [NT-1:0] trie_feed;
   logic [NS-1:0] scan_act;
   logic [NS-1:0] scan_fit;
   logic [NS-1:0] scan_feed;

   sipsm_pkg::cell_ctrl_type trie_ctrl;
   sipsm_pkg::cell_ctrl_type scan_ctrl;

   assign req_chan.ready  = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.is_sip = is_sip_ff;

   assign accept    = req_chan.valid && req_chan.ready;
   assign data_byte = req_chan.payload_byte;
   assign zero_byte = (data_byte == sipsm_pkg::CHR_NUL);
   assign live_byte = accept && !ended_ff && !zero_byte && !match_ff;
   assign trie_step = live_byte && !scan_on_ff;
   assign scan_step = live_byte && scan_on_ff;
   assign clear     = accept && req_chan.last_byte;

   assign trie_ctrl = '{step: trie_step, clear: clear};
   assign scan_ctrl = '{step: scan_step, clear: clear};

   genvar gi;
   generate
      for (gi = 0; gi < NT; gi++) begin : g_trie
         if (sipsm_pkg::key_start(gi)) begin : g_head
            assign trie_feed[gi] = start_ff;
         end else begin : g_body
            assign trie_feed[gi] = trie_act[gi-1];
         end
         sipsm_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (trie_ctrl),
            .feed       (trie_feed[gi]),
            .pat_char   (sipsm_pkg::trie_char(gi)),
            .data_byte  (data_byte),
            .active_out (trie_act[gi]),
            .fit_out    (trie_fit[gi])
         );
      end
      for (gi = 0; gi < NS; gi++) begin : g_scan
         if (gi == 0) begin : g_head
            assign scan_feed[gi] = 1'b1;
         end else begin : g_body
            assign scan_feed[gi] = scan_act[gi-1];
         end
         sipsm_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (scan_ctrl),
            .feed       (scan_feed[gi]),
            .pat_char   (sipsm_pkg::scan_char(gi)),
            .data_byte  (data_byte),
            .active_out (scan_act[gi]),
            .fit_out    (scan_fit[gi])
         );
      end
   endgenerate

   assign key_done  = trie_step && (|(trie_fit & sipsm_pkg::KEY_END_MASK));
   assign upd_done  = trie_step && trie_fit[sipsm_pkg::UPD_END];
   assign scan_done = scan_step && scan_fit[NS-1];
   assign match_now = match_ff || key_done || scan_done;

   always_comb begin
      start_in     = start_ff;
      ended_in     = ended_ff;
      match_in     = match_ff;
      scan_on_in   = scan_on_ff;
      rsp_valid_in = rsp_valid_ff;
      is_sip_in    = is_sip_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (clear) begin
         start_in     = 1'b1;
         ended_in     = 1'b0;
         match_in     = 1'b0;
         scan_on_in   = 1'b0;
         rsp_valid_in = 1'b1;
         is_sip_in    = match_now;
      end else if (accept) begin
         ended_in = ended_ff || zero_byte;
         match_in = match_now;
         if (trie_step) begin
            start_in = 1'b0;
         end
         if (upd_done) begin
            scan_on_in = 1'b1;
         end
         if (scan_done) begin
            scan_on_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= 1'b1;
         ended_ff     <= 1'b0;
         match_ff     <= 1'b0;
         scan_on_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         ended_ff     <= ended_in;
         match_ff     <= match_in;
         scan_on_ff   <= scan_on_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      is_sip_ff <= is_sip_in;
   end

   a_scan_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(scan_act))
      else $error("more than one scan cell active");

   a_start_vs_scan: assert property (@(posedge clock) disable iff (reset)
      !(start_ff && scan_on_ff))
      else $error("scan running before any keyword byte");

   a_match_stops_scan: assert property (@(posedge clock) disable iff (reset)
      match_ff |-> !scan_on_ff)
      else $error("scan still running after a match");

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      clear |=> rsp_valid_ff)
      else $error("last word accepted without a response");

endmodule
